FILE: src/tkc_pkg.sv
// Shared types, constants and round function for the keystream cipher core.
// No dependencies; imported by the core.
`default_nettype none

package tkc_pkg;

  // Register lengths, default warm-up length and configuration widths
  localparam int unsigned A_LEN          = 93;
  localparam int unsigned B_LEN          = 84;
  localparam int unsigned C_LEN          = 111;
  localparam int unsigned WARMUP_DEFAULT = 1152;
  localparam int unsigned CFG_W          = 64;
  localparam int unsigned HALF_KEY_W     = 16;

  // Configuration register indexes
  localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [1:0] CFG_KEY_HIGH = 2'd1;
  localparam logic [1:0] CFG_IV_LOW   = 2'd2;
  localparam logic [1:0] CFG_IV_HIGH  = 2'd3;

  typedef struct packed {
    logic [A_LEN-1:0] a;
    logic [B_LEN-1:0] b;
    logic [C_LEN-1:0] c;
  } tkc_state_t;

  // Keystream bit of the current state
  function automatic logic tkc_ks_bit(input tkc_state_t s);
    logic ta, tb, tc;
    ta = s.a[65] ^ (s.a[90] & s.a[91]) ^ s.a[92];
    tb = s.b[68] ^ (s.b[81] & s.b[82]) ^ s.b[83];
    tc = s.c[65] ^ (s.c[108] & s.c[109]) ^ s.c[110];
    return ta ^ tb ^ tc;
  endfunction

  // One round: shift every register left, feed back the crossed taps
  function automatic tkc_state_t tkc_round(input tkc_state_t s);
    logic ta, tb, tc;
    tkc_state_t n;
    ta  = s.a[65] ^ (s.a[90] & s.a[91]) ^ s.a[92];
    tb  = s.b[68] ^ (s.b[81] & s.b[82]) ^ s.b[83];
    tc  = s.c[65] ^ (s.c[108] & s.c[109]) ^ s.c[110];
    n.a = {s.a[A_LEN-2:0], s.a[68] ^ tc};
    n.b = {s.b[B_LEN-2:0], s.b[77] ^ ta};
    n.c = {s.c[C_LEN-2:0], s.c[86] ^ tb};
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: src/trivium_like_keystream_cipher_core.sv
// A request without restart runs eight rounds on the current state, then hands off
// its result; with restart the core first loads key/IV and runs the warm-up.
// No new request is taken until the last result is handed off, which waits while
// a result is stalled; the single round unit does one round per cycle.
// Reset (rst, synchronous): cipher state, key and IV clear to zero; core goes idle.
// Depends on tkc_pkg.
`default_nettype none

module trivium_like_keystream_cipher_core
  import tkc_pkg::*;
#(
  parameter int unsigned WARMUP_ROUNDS = WARMUP_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // configuration write port
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  // input requests
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             restart,
  input  wire logic [7:0]       data_byte,
  // results
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            cipher_byte
);

  localparam int unsigned CNT_W = $clog2(WARMUP_ROUNDS + 2);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WARM = 2'd1;
  localparam logic [1:0] ST_BYTE = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]            state;
  logic [CNT_W-1:0]      warm_cnt;
  logic [2:0]            bit_cnt;
  logic [7:0]            data;
  logic [7:0]            ks;
  tkc_state_t            cs;
  tkc_state_t            cs_round;
  tkc_state_t            cs_load;
  logic                  ks_bit;
  logic [CFG_W-1:0]      key_low, iv_low;
  logic [HALF_KEY_W-1:0] key_high, iv_high;
  logic                  out_free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
      iv_low   <= '0;
      iv_high  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_LOW:  key_low  <= cfg_data;
        CFG_KEY_HIGH: key_high <= cfg_data[HALF_KEY_W-1:0];
        CFG_IV_LOW:   iv_low   <= cfg_data;
        CFG_IV_HIGH:  iv_high  <= cfg_data[HALF_KEY_W-1:0];
        default: ;
      endcase
    end
  end

  // Shared round unit and load value
  assign cs_round  = tkc_round(cs);
  assign ks_bit    = tkc_ks_bit(cs);
  assign cs_load.a = {(A_LEN - HALF_KEY_W - CFG_W)'(0), iv_high, iv_low};
  assign cs_load.b = {(B_LEN - HALF_KEY_W - CFG_W)'(0), key_high, key_low};
  assign cs_load.c = {3'b111, (C_LEN - 3)'(0)};

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // Sequencer: on restart load and warm up, then run eight rounds, hand off the byte
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cs       <= '0;
      warm_cnt <= '0;
      bit_cnt  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            bit_cnt  <= '0;
            warm_cnt <= '0;
            if (restart) begin
              cs    <= cs_load;
              state <= (WARMUP_ROUNDS == 0) ? ST_BYTE : ST_WARM;
            end else begin
              state <= ST_BYTE;
            end
          end
        end
        ST_WARM: begin
          cs       <= cs_round;
          warm_cnt <= warm_cnt + 1'b1;
          if (warm_cnt == CNT_W'(WARMUP_ROUNDS - 1)) begin
            state <= ST_BYTE;
          end
        end
        ST_BYTE: begin
          cs      <= cs_round;
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == 3'd7) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Capture the data byte and collect keystream bits, first one at the MSB
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      data <= data_byte;
    end
    if (state == ST_BYTE) begin
      ks <= {ks[6:0], ks_bit};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      cipher_byte <= data ^ ks;
    end
  end

endmodule

`default_nettype wire

FILE: src/tkc_checker.sv
// Port-level checker for the keystream cipher core, bound to the core.
// Depends on trivium_like_keystream_cipher_core.
`default_nettype none

module tkc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] cipher_byte
);

  // An accepted request keeps the core busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("core ready right after accepting a request");

  // No result can appear the cycle after a request is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared one cycle after accept");

  // A new result is handed off exactly when the core goes idle again
  a_result_with_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $rose(in_ready))
    else $error("result raised without finishing a request");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cipher_byte))
    else $error("stalled result changed or dropped");

endmodule

bind trivium_like_keystream_cipher_core tkc_checker u_tkc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .cipher_byte (cipher_byte)
);

`default_nettype wire
